[src/gcsm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcsm_pkg
// Shared types, codes and constants for the grid cone stamp mask core.
// ----------------------------------------------------------------------------
package gcsm_pkg;

   // Default grid and radius limits
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_MAX_RADIUS = 15;

   localparam int GRID_W     = 9;   // grid size register width
   localparam int RAD_W      = 6;   // radius width (max radius 63)
   localparam int OFS_W      = 7;   // signed kernel offset
   localparam int COORD_W    = 10;  // signed cell coordinate during a stamp
   localparam int D_W        = 12;  // squared distance inside the cone
   localparam int ALPHA_W    = 13;
   localparam int SQRT_STEPS = 14;  // root bits of floor(256*sqrt(d))
   localparam int DIV_STEPS  = 13;  // quotient bits of the cone ramp
   localparam int NUM_W      = 19;
   localparam int DSR_W      = 7;

   localparam logic [ALPHA_W-1:0] ONE_Q12 = 13'd4096;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_STAMP = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_FULL_RADIUS   = 2'd0,
      REG_CUTOFF_RADIUS = 2'd1,
      REG_GRID_WIDTH    = 2'd2,
      REG_GRID_HEIGHT   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         cell_x;
      logic [7:0]         cell_y;
      logic [7:0]         base_cost;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
   } req_type;

   typedef struct packed {
      logic [7:0]          reduced_cost;
      logic signed [15:0]  masked_dir_x;
      logic signed [15:0]  masked_dir_y;
      logic [ALPHA_W-1:0]  alpha;
   } rsp_type;

   // Per-stamp cone shape: cutoff radius and cutoff minus full radius (at least 1)
   typedef struct packed {
      logic [RAD_W-1:0] c;
      logic [RAD_W-1:0] k;
   } cone_cfg_type;

   typedef struct packed {
      logic           valid;
      logic           full;
      logic [D_W-1:0] d;
   } cone_req_type;

   typedef struct packed {
      logic               valid;
      logic [ALPHA_W-1:0] alpha;
   } cone_rsp_type;

endpackage
`default_nettype wire

[src/gcsm_cone.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gcsm_cone
// Pipelined cone value: floor(256*sqrt(d)) by digit steps, then the ramp
// divide by restoring steps. One offset per cycle, fixed latency.
// ----------------------------------------------------------------------------
module gcsm_cone import gcsm_pkg::*; #(
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cone_cfg_type      cfg,
   input  cone_req_type      req,
   input  logic [ADDR_W-1:0] req_addr,
   output cone_rsp_type      rsp,
   output logic [ADDR_W-1:0] rsp_addr,
   output logic              busy
);

   function automatic logic [1:0] root_pair(input logic [D_W-1:0] d, input int p);
      logic [2*SQRT_STEPS-1:0] n;
      n = {d, 16'h0000};
      return n[2*p +: 2];
   endfunction

   // returns {remainder, root}
   function automatic logic [29:0] sqrt_step(input logic [15:0] rem,
                                             input logic [13:0] root,
                                             input logic [1:0]  pair);
      logic [17:0] r;
      logic [17:0] trial;
      logic [17:0] diff;
      r     = {rem, pair};
      trial = {2'b00, root, 2'b01};
      diff  = r - trial;
      if (r >= trial) begin
         return {diff[15:0], root[12:0], 1'b1};
      end else begin
         return {r[15:0], root[12:0], 1'b0};
      end
   endfunction

   // returns {remainder, quotient}
   function automatic logic [31:0] div_step(input logic [NUM_W-1:0]     rem,
                                            input logic [DIV_STEPS-1:0] q,
                                            input logic [DSR_W-1:0]     dsr,
                                            input int                   j);
      logic [NUM_W:0] rem_x;
      logic [NUM_W:0] sh;
      logic [NUM_W:0] diff;
      rem_x = {1'b0, rem};
      sh    = (NUM_W+1)'(dsr) << j;
      diff  = rem_x - sh;
      if (rem_x >= sh) begin
         return {diff[NUM_W-1:0], q | (DIV_STEPS'(1) << j)};
      end else begin
         return {rem, q};
      end
   endfunction

   logic [SQRT_STEPS-1:0] sq_valid_ff;
   logic [SQRT_STEPS-1:0] sq_full_ff;
   logic [D_W-1:0]        sq_d_ff    [SQRT_STEPS];
   logic [15:0]           sq_rem_ff  [SQRT_STEPS];
   logic [13:0]           sq_root_ff [SQRT_STEPS];
   logic [ADDR_W-1:0]     sq_addr_ff [SQRT_STEPS];

   logic                  pr_valid_ff;
   logic                  pr_full_ff;
   logic [NUM_W-1:0]      pr_num_ff;
   logic [ADDR_W-1:0]     pr_addr_ff;

   logic [DIV_STEPS-1:0]  dv_valid_ff;
   logic [DIV_STEPS-1:0]  dv_full_ff;
   logic [NUM_W-1:0]      dv_rem_ff  [DIV_STEPS];
   logic [DIV_STEPS-1:0]  dv_q_ff    [DIV_STEPS];
   logic [ADDR_W-1:0]     dv_addr_ff [DIV_STEPS];

   logic [13:0]           c256;
   logic [13:0]           root_last;
   logic [13:0]           ramp_in;
   logic [NUM_W-1:0]      num_in;
   logic [DSR_W-1:0]      dsr;
   logic [DIV_STEPS-1:0]  q_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '0;
         pr_valid_ff <= 1'b0;
         dv_valid_ff <= '0;
      end else begin
         sq_valid_ff <= {sq_valid_ff[SQRT_STEPS-2:0], req.valid};
         pr_valid_ff <= sq_valid_ff[SQRT_STEPS-1];
         dv_valid_ff <= {dv_valid_ff[DIV_STEPS-2:0], pr_valid_ff};
      end
   end

   // square root digit steps
   always_ff @(posedge clock) begin
      sq_full_ff <= {sq_full_ff[SQRT_STEPS-2:0], req.full};
      sq_d_ff[0]    <= req.d;
      sq_addr_ff[0] <= req_addr;
      {sq_rem_ff[0], sq_root_ff[0]} <=
         sqrt_step(16'd0, 14'd0, root_pair(req.d, SQRT_STEPS-1));
      for (int i = 1; i < SQRT_STEPS; i++) begin
         sq_d_ff[i]    <= sq_d_ff[i-1];
         sq_addr_ff[i] <= sq_addr_ff[i-1];
         {sq_rem_ff[i], sq_root_ff[i]} <=
            sqrt_step(sq_rem_ff[i-1], sq_root_ff[i-1],
                      root_pair(sq_d_ff[i-1], SQRT_STEPS-1-i));
      end
   end

   // ramp numerator 32*(256c - s) + k over divisor 2k gives the rounded level
   assign c256      = {cfg.c, 8'h00};
   assign root_last = sq_root_ff[SQRT_STEPS-1];
   assign ramp_in   = (root_last > c256) ? 14'd0 : (c256 - root_last);
   assign num_in    = {ramp_in, 5'b00000} + NUM_W'(cfg.k);
   assign dsr       = {cfg.k, 1'b0};

   always_ff @(posedge clock) begin
      pr_full_ff <= sq_full_ff[SQRT_STEPS-1];
      pr_num_ff  <= num_in;
      pr_addr_ff <= sq_addr_ff[SQRT_STEPS-1];
   end

   // restoring divide steps
   always_ff @(posedge clock) begin
      dv_full_ff    <= {dv_full_ff[DIV_STEPS-2:0], pr_full_ff};
      dv_addr_ff[0] <= pr_addr_ff;
      {dv_rem_ff[0], dv_q_ff[0]} <= div_step(pr_num_ff, '0, dsr, DIV_STEPS-1);
      for (int m = 1; m < DIV_STEPS; m++) begin
         dv_addr_ff[m] <= dv_addr_ff[m-1];
         {dv_rem_ff[m], dv_q_ff[m]} <=
            div_step(dv_rem_ff[m-1], dv_q_ff[m-1], dsr, DIV_STEPS-1-m);
      end
   end

   assign q_last    = dv_q_ff[DIV_STEPS-1];
   assign rsp.valid = dv_valid_ff[DIV_STEPS-1];
   assign rsp.alpha = (dv_full_ff[DIV_STEPS-1] || q_last > ONE_Q12) ? ONE_Q12 : q_last;
   assign rsp_addr  = dv_addr_ff[DIV_STEPS-1];
   assign busy      = (|sq_valid_ff) | pr_valid_ff | (|dv_valid_ff);

endmodule
`default_nettype wire

[src/grid_cone_stamp_mask_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grid_cone_stamp_mask_core
// Grid of cells with cost, direction and mask level; cone stamps raise the
// mask level by read-modify-write of the level memory.
//
//  channel  dir  handshake            transaction
//  req_     in   req_valid/req_stall  load, stamp or read of one cell
//  rsp_     out  rsp_valid/rsp_stall  read result (cost, direction, level)
//  csr_     in   csr_valid/csr_ready  register index and write data
//
//  Load: written when taken. Read: through the memory read registers, then
//  into the output register. Stamp: offset scan over dx, dy from -c to c, one
//  offset per cycle, then the cone pipe and the level memory update drain.
//  Reset is synchronous; afterwards the level memory is swept to zero with
//  req_stall high (csr writes still taken).
//  A waiting result does not stall loads or stamps; a read waits for the
//  output register to free.
// ----------------------------------------------------------------------------
module grid_cone_stamp_mask_core import gcsm_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [GRID_W-1:0] csr_data
);

   localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int W_CLIP = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
   localparam int H_CLIP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_READ  = 5'b10000
   } state_type;

   // direction times level, rounded half away from zero
   function automatic logic [15:0] scale_dir(input logic signed [15:0] v,
                                             input logic [ALPHA_W-1:0] a);
      logic [16:0] mag;
      logic [29:0] prod;
      logic [16:0] r;
      mag  = v[15] ? (17'd0 - 17'(v)) : 17'(v);
      prod = 30'(mag) * 30'(a) + 30'd2048;
      r    = prod[28:12];
      return v[15] ? 16'(17'd0 - r) : r[15:0];
   endfunction

   // ---------------- configuration ----------------
   logic [3:0]        full_radius_ff;
   logic [3:0]        cutoff_radius_ff;
   logic [GRID_W-1:0] grid_width_ff;
   logic [GRID_W-1:0] grid_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_radius_ff   <= 4'd2;
         cutoff_radius_ff <= 4'd5;
         grid_width_ff    <= 9'd256;
         grid_height_ff   <= 9'd256;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_FULL_RADIUS:   full_radius_ff   <= csr_data[3:0];
            REG_CUTOFF_RADIUS: cutoff_radius_ff <= csr_data[3:0];
            REG_GRID_WIDTH:    grid_width_ff    <= csr_data;
            REG_GRID_HEIGHT:   grid_height_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic [GRID_W-1:0] eff_w;
   logic [GRID_W-1:0] eff_h;
   logic [RAD_W-1:0]  c_eff;
   logic [RAD_W-1:0]  f_ext;

   assign eff_w = (grid_width_ff  < GRID_W'(W_CLIP)) ? grid_width_ff  : GRID_W'(W_CLIP);
   assign eff_h = (grid_height_ff < GRID_W'(H_CLIP)) ? grid_height_ff : GRID_W'(H_CLIP);
   assign c_eff = (RAD_W'(cutoff_radius_ff) < RAD_W'(MAX_RADIUS)) ?
                  RAD_W'(cutoff_radius_ff) : RAD_W'(MAX_RADIUS);
   assign f_ext = RAD_W'(full_radius_ff);

   // ---------------- request decode ----------------
   state_type         state_ff, state_in;
   logic              req_take;
   logic              req_inside;
   logic [ADDR_W-1:0] req_addr;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign req_inside = ({1'b0, req_data.cell_x} < eff_w) && ({1'b0, req_data.cell_y} < eff_h);
   assign req_addr   = ADDR_W'(32'(req_data.cell_y) * 32'(MAX_WIDTH) + 32'(req_data.cell_x));

   // ---------------- stamp scan ----------------
   logic [7:0]              ctr_x_ff, ctr_y_ff;
   logic [RAD_W-1:0]        c_ff, k_ff;
   logic [D_W-1:0]          csq_ff;
   logic [7:0]              fsq_ff;
   logic signed [OFS_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [OFS_W-1:0] c_pos, c_neg;
   logic                    scan_last;

   assign c_pos     = $signed({1'b0, c_ff});
   assign c_neg     = -c_pos;
   assign scan_last = (dx_ff == c_pos) && (dy_ff == c_pos);

   always_comb begin
      dx_in = dx_ff;
      dy_in = dy_ff;
      if (dx_ff == c_pos) begin
         dx_in = c_neg;
         dy_in = dy_ff + OFS_W'(1);
      end else begin
         dx_in = dx_ff + OFS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_take && req_data.cmd == CMD_STAMP) begin
         ctr_x_ff <= req_data.cell_x;
         ctr_y_ff <= req_data.cell_y;
         c_ff     <= c_eff;
         csq_ff   <= D_W'(c_eff) * D_W'(c_eff);
         fsq_ff   <= 8'(full_radius_ff) * 8'(full_radius_ff);
         k_ff     <= (f_ext < c_eff) ? (c_eff - f_ext) : RAD_W'(1);
         dx_ff    <= -$signed({1'b0, c_eff});
         dy_ff    <= -$signed({1'b0, c_eff});
      end else if (state_ff == ST_SCAN) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // offset stage: distance, grid test, cell address
   logic [RAD_W-1:0]          mag_dx, mag_dy;
   logic [D_W:0]              d_sum;
   logic signed [COORD_W-1:0] px, py;
   logic                      off_hit;
   logic                      p0_valid_ff;
   logic                      p0_full_ff;
   logic [D_W-1:0]            p0_d_ff;
   logic [ADDR_W-1:0]         p0_addr_ff;

   assign mag_dx  = dx_ff[OFS_W-1] ? RAD_W'(-dx_ff) : dx_ff[RAD_W-1:0];
   assign mag_dy  = dy_ff[OFS_W-1] ? RAD_W'(-dy_ff) : dy_ff[RAD_W-1:0];
   assign d_sum   = (D_W+1)'(mag_dx) * (D_W+1)'(mag_dx)
                    + (D_W+1)'(mag_dy) * (D_W+1)'(mag_dy);
   assign px      = $signed({2'b00, ctr_x_ff}) + COORD_W'(dx_ff);
   assign py      = $signed({2'b00, ctr_y_ff}) + COORD_W'(dy_ff);
   assign off_hit = (state_ff == ST_SCAN) && (d_sum <= (D_W+1)'(csq_ff))
                    && !px[COORD_W-1] && (px[GRID_W-1:0] < eff_w)
                    && !py[COORD_W-1] && (py[GRID_W-1:0] < eff_h);

   always_ff @(posedge clock) begin
      if (reset) p0_valid_ff <= 1'b0;
      else       p0_valid_ff <= off_hit;
   end

   always_ff @(posedge clock) begin
      p0_d_ff    <= d_sum[D_W-1:0];
      p0_full_ff <= d_sum <= (D_W+1)'(fsq_ff);
      p0_addr_ff <= ADDR_W'(32'(py[GRID_W-1:0]) * 32'(MAX_WIDTH) + 32'(px[GRID_W-1:0]));
   end

   // cone value pipe
   cone_cfg_type      cone_cfg;
   cone_req_type      cone_req;
   cone_rsp_type      cone_rsp;
   logic [ADDR_W-1:0] cone_addr;
   logic              cone_busy;

   assign cone_cfg = '{c: c_ff, k: k_ff};
   assign cone_req = '{valid: p0_valid_ff, full: p0_full_ff, d: p0_d_ff};

   gcsm_cone #(.ADDR_W(ADDR_W)) u_cone (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cone_cfg),
      .req      (cone_req),
      .req_addr (p0_addr_ff),
      .rsp      (cone_rsp),
      .rsp_addr (cone_addr),
      .busy     (cone_busy)
   );

   // ---------------- memories ----------------
   // Offsets of one stamp hit distinct cells, so the read of one offset
   // never meets the pending write of the one before it.
   logic [ALPHA_W-1:0] alpha_mem [CELLS];
   logic [39:0]        cell_mem  [CELLS];

   logic               rmw_valid_ff;
   logic [ADDR_W-1:0]  rmw_addr_ff;
   logic [ALPHA_W-1:0] rmw_alpha_ff;
   logic [ADDR_W-1:0]  clr_cnt_ff;

   logic [ALPHA_W-1:0] alpha_rd_ff;
   logic [39:0]        cell_rd_ff;

   logic               alpha_re, alpha_we, cell_we, cell_re;
   logic [ADDR_W-1:0]  alpha_raddr, alpha_waddr;
   logic [ALPHA_W-1:0] alpha_wdata;
   logic               load_hit;

   assign load_hit    = req_take && req_data.cmd == CMD_LOAD && req_inside;
   assign alpha_re    = cone_rsp.valid || (req_take && req_data.cmd == CMD_READ && req_inside);
   assign alpha_raddr = cone_rsp.valid ? cone_addr : req_addr;
   assign cell_we     = load_hit;
   assign cell_re     = req_take && req_data.cmd == CMD_READ && req_inside;

   always_comb begin
      alpha_we    = 1'b0;
      alpha_waddr = req_addr;
      alpha_wdata = '0;
      priority if (state_ff == ST_CLEAR) begin
         alpha_we    = 1'b1;
         alpha_waddr = clr_cnt_ff;
      end else if (rmw_valid_ff) begin
         alpha_we    = rmw_alpha_ff > alpha_rd_ff;
         alpha_waddr = rmw_addr_ff;
         alpha_wdata = rmw_alpha_ff;
      end else if (load_hit) begin
         alpha_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (alpha_we) alpha_mem[alpha_waddr] <= alpha_wdata;
      if (alpha_re) alpha_rd_ff <= alpha_mem[alpha_raddr];
   end

   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[req_addr] <= {req_data.dir_y, req_data.dir_x, req_data.base_cost};
      if (cell_re) cell_rd_ff <= cell_mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) rmw_valid_ff <= 1'b0;
      else       rmw_valid_ff <= cone_rsp.valid;
   end

   always_ff @(posedge clock) begin
      rmw_addr_ff  <= cone_addr;
      rmw_alpha_ff <= cone_rsp.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset)                   clr_cnt_ff <= '0;
      else if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
   end

   // ---------------- control ----------------
   logic rsp_valid_ff;
   logic slot_free;
   logic rd_zero_ff;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == ADDR_W'(CELLS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.cmd == CMD_STAMP && req_inside) state_in = ST_SCAN;
               else if (req_data.cmd == CMD_READ)           state_in = ST_READ;
            end
         end
         ST_SCAN:  if (scan_last) state_in = ST_DRAIN;
         ST_DRAIN: if (!p0_valid_ff && !cone_busy && !rmw_valid_ff) state_in = ST_IDLE;
         ST_READ:  if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) rd_zero_ff <= !req_inside;
   end

   // ---------------- result register ----------------
   rsp_type            rsp_data_ff;
   logic [ALPHA_W-1:0] rd_a;
   logic [20:0]        cost_prod;
   rsp_type            rsp_calc;

   assign rd_a      = (alpha_rd_ff > ONE_Q12) ? ONE_Q12 : alpha_rd_ff;
   assign cost_prod = 21'(cell_rd_ff[7:0]) * 21'(ONE_Q12 - rd_a) + 21'd2048;

   always_comb begin
      rsp_calc = '0;
      if (!rd_zero_ff) begin
         rsp_calc.reduced_cost = cost_prod[19:12];
         rsp_calc.masked_dir_x = scale_dir(cell_rd_ff[23:8], rd_a);
         rsp_calc.masked_dir_y = scale_dir(cell_rd_ff[39:24], rd_a);
         rsp_calc.alpha        = rd_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_READ && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ && slot_free) rsp_data_ff <= rsp_calc;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ))
      else $error("result raised outside a read transaction");

   a_cone_in_stamp: assert property (@(posedge clock) disable iff (reset)
      cone_rsp.valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("cone value outside a stamp");

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      alpha_we |-> alpha_wdata <= ONE_Q12)
      else $error("mask level above one written");

   a_rmw_in_stamp: assert property (@(posedge clock) disable iff (reset)
      rmw_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("level update outside a stamp");

endmodule
`default_nettype wire
